FILE: rtl/hsfc_pkg.sv
// Shared types and constants for the hash slot find-or-claim block.
// Holds the FNV-1a constants, field widths and sequencer state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsfc_pkg;

   // Field widths fixed by the item format.
   localparam int KEY_W      = 32;
   localparam int SIZE_W     = 7;
   localparam int SLOT_OUT_W = 6;
   // Width of the effective size and the remainder (the cap can reach 128).
   localparam int NUM_W      = 8;

   // Reset value of the table size register.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // FNV-1a 32-bit constants.
   localparam logic [KEY_W-1:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [KEY_W-1:0] FNV_PRIME = 32'h0100_0193;

   // Result status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Hash unit sequencer states.
   typedef enum logic [1:0] {
      H_IDLE,
      H_MIX,
      H_MOD,
      H_DONE
   } hsfc_hstate_type;

   // Top-level sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_CMP
   } hsfc_state_type;

endpackage

`default_nettype wire

FILE: rtl/hash_slot_find_or_claim_core.sv
// Find-or-claim lookup in a linear-probing hash table of 32-bit keys.
// Depends on hsfc_pkg and hsfc_hash_unit.
//
// Usage:
//   An item enters on req_valid/req_ready carrying req_key. The block hashes
//   the key (FNV-1a), reduces it modulo the effective table size and probes
//   slots forward with wrap-around. It returns one item on rsp_valid/rsp_ready:
//   rsp_status (0 found or claimed, 1 table full), rsp_slot and
//   rsp_newly_claimed. The user must write the table size through csr_wr_en and
//   csr_wr_data only while the block is idle; the block does not enforce
//   this. 0 acts as 1, and sizes above the table depth act as the depth.
// Sequence:
//   Hashing runs the FNV-1a rounds on the shared multiplier, then the
//   remainder four bits at a time, then a handoff state. Each occupied slot
//   visited takes a key memory read, then a compare. The block works on one
//   item at a time; req_ready is high only while idle.
// Reset: all slots become empty and the size returns to 64; no clearing pass
//   is needed. A finished item waits in the output register if rsp_ready is
//   low; the next item may be taken meanwhile, and its completion waits until
//   the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module hash_slot_find_or_claim_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [hsfc_pkg::KEY_W-1:0]      req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_status,
   output logic [hsfc_pkg::SLOT_OUT_W-1:0] rsp_slot,
   output logic                            rsp_newly_claimed,
   input  logic                            csr_wr_en,
   input  logic [hsfc_pkg::SIZE_W-1:0]     csr_wr_data
);

   localparam int KW     = hsfc_pkg::KEY_W;
   localparam int NW     = hsfc_pkg::NUM_W;
   localparam int SZW    = hsfc_pkg::SIZE_W;
   localparam int OSW    = hsfc_pkg::SLOT_OUT_W;
   // The size register cannot reach past 127, so slots beyond 128 are never used.
   localparam int SLOTS  = (TABLE_DEPTH < 128) ? TABLE_DEPTH : 128;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   hsfc_pkg::hsfc_state_type state_ff, state_in;

   logic [SZW-1:0]    size_ff;
   logic [KW-1:0]     key_ff;
   logic [NW-1:0]     num_ff;
   logic [NW-1:0]     num_eff;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [NW-1:0]     cnt_ff, cnt_in;
   logic [SLOTS-1:0]  used_ff;
   logic [KW-1:0]     key_mem [SLOTS];
   logic [KW-1:0]     rdata_ff;

   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [OSW-1:0]    rsp_slot_ff;
   logic              rsp_new_ff;

   logic              accept;
   logic              hash_done;
   logic [NW-1:0]     hash_rem;
   logic              out_free;
   logic              slot_free;
   logic              hit;
   logic              last;
   logic              at_end;
   logic              do_claim;
   logic              do_found;
   logic              do_full;
   logic              do_next;

   // Effective size: zero acts as one, large values clamp to the depth.
   always_comb begin
      if (size_ff == '0) begin
         num_eff = NW'(1);
      end else if (NW'(size_ff) > NW'(SLOTS)) begin
         num_eff = NW'(SLOTS);
      end else begin
         num_eff = NW'(size_ff);
      end
   end

   hsfc_hash_unit u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_key),
      .num   (num_eff),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   // Probe decisions.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_free = !used_ff[idx_ff];
   assign hit       = (rdata_ff == key_ff);
   assign last      = (cnt_ff == num_ff - NW'(1));
   assign at_end    = (NW'(idx_ff) == num_ff - NW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsfc_pkg::S_IDLE: begin
            if (req_valid) state_in = hsfc_pkg::S_HASH;
         end
         hsfc_pkg::S_HASH: begin
            if (hash_done) state_in = hsfc_pkg::S_PROBE;
         end
         hsfc_pkg::S_PROBE: begin
            if (!slot_free) begin
               state_in = hsfc_pkg::S_CMP;
            end else if (out_free) begin
               state_in = hsfc_pkg::S_IDLE;
            end
         end
         hsfc_pkg::S_CMP: begin
            if (!hit && !last) begin
               state_in = hsfc_pkg::S_PROBE;
            end else if (out_free) begin
               state_in = hsfc_pkg::S_IDLE;
            end
         end
         default: state_in = hsfc_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      do_claim  = 1'b0;
      do_found  = 1'b0;
      do_full   = 1'b0;
      do_next   = 1'b0;
      case (state_ff)
         hsfc_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         hsfc_pkg::S_PROBE: begin
            do_claim = slot_free && out_free;
         end
         hsfc_pkg::S_CMP: begin
            do_found = hit && out_free;
            do_full  = !hit && last && out_free;
            do_next  = !hit && !last;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // Probe index and probe count.
   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (hash_done && state_ff == hsfc_pkg::S_HASH) begin
         idx_in = hash_rem[SLOT_W-1:0];
         cnt_in = '0;
      end else if (do_next) begin
         idx_in = at_end ? '0 : idx_ff + SLOT_W'(1);
         cnt_in = cnt_ff + NW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsfc_pkg::S_IDLE;
         size_ff      <= hsfc_pkg::SIZE_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (do_claim) begin
            used_ff[idx_ff] <= 1'b1;
         end
         if (do_claim || do_found || do_full) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item payload, probe state and result registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_key;
         num_ff <= num_eff;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (do_claim || do_found) begin
         rsp_status_ff <= hsfc_pkg::STATUS_OK;
         rsp_slot_ff   <= OSW'(idx_ff);
         rsp_new_ff    <= do_claim;
      end else if (do_full) begin
         rsp_status_ff <= hsfc_pkg::STATUS_FULL;
         rsp_slot_ff   <= '0;
         rsp_new_ff    <= 1'b0;
      end
   end

   // Key memory: written when a slot is claimed, read data registered.
   always_ff @(posedge clock) begin
      if (do_claim) begin
         key_mem[idx_ff] <= key_ff;
      end
      rdata_ff <= key_mem[idx_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_newly_claimed = rsp_new_ff;

endmodule

`default_nettype wire

FILE: rtl/hsfc_hash_unit.sv
// Iterative FNV-1a hash followed by a remainder by the effective table size.
// One shared multiplier does a byte per cycle; the remainder takes four bits a cycle.
// Depends on hsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsfc_hash_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hsfc_pkg::KEY_W-1:0] key,
   input  logic [hsfc_pkg::NUM_W-1:0] num,
   output logic                       done,
   output logic [hsfc_pkg::NUM_W-1:0] rem
);

   localparam int KW = hsfc_pkg::KEY_W;
   localparam int NW = hsfc_pkg::NUM_W;

   hsfc_pkg::hsfc_hstate_type state_ff, state_in;

   logic [KW-1:0]   hash_ff, hash_in;
   logic [KW-1:0]   key_ff, key_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [2:0]      cnt_ff, cnt_in;

   logic [KW-1:0]   product;
   logic [KW-1:0]   mixed;
   logic [NW-1:0]   rem_step;

   // One FNV-1a round on the lowest remaining key byte, kept modulo 2^32.
   assign mixed   = hash_ff ^ {{(KW-8){1'b0}}, key_ff[7:0]};
   assign product = mixed * hsfc_pkg::FNV_PRIME;

   // Four restoring remainder steps, most significant hash bits first.
   always_comb begin
      logic [NW-1:0] r;
      r = rem_ff;
      for (int j = 0; j < 4; j++) begin
         r = {r[NW-2:0], hash_ff[KW-1-j]};
         if (r >= num_ff) begin
            r = r - num_ff;
         end
      end
      rem_step = r;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsfc_pkg::H_IDLE: begin
            if (start) state_in = hsfc_pkg::H_MIX;
         end
         hsfc_pkg::H_MIX: begin
            if (cnt_ff == 3'd3) state_in = hsfc_pkg::H_MOD;
         end
         hsfc_pkg::H_MOD: begin
            if (cnt_ff == 3'd7) state_in = hsfc_pkg::H_DONE;
         end
         hsfc_pkg::H_DONE: begin
            state_in = hsfc_pkg::H_IDLE;
         end
         default: state_in = hsfc_pkg::H_IDLE;
      endcase
   end

   // Datapath updates per state.
   always_comb begin
      hash_in = hash_ff;
      key_in  = key_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      case (state_ff)
         hsfc_pkg::H_IDLE: begin
            hash_in = hsfc_pkg::FNV_BASIS;
            key_in  = key;
            num_in  = num;
            rem_in  = '0;
            cnt_in  = '0;
         end
         hsfc_pkg::H_MIX: begin
            hash_in = product;
            key_in  = key_ff >> 8;
            cnt_in  = (cnt_ff == 3'd3) ? 3'd0 : cnt_ff + 3'd1;
         end
         hsfc_pkg::H_MOD: begin
            hash_in = hash_ff << 4;
            rem_in  = rem_step;
            cnt_in  = cnt_ff + 3'd1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      done = (state_ff == hsfc_pkg::H_DONE);
      rem  = rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsfc_pkg::H_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      key_ff  <= key_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

`default_nettype wire

FILE: tb/hash_slot_find_or_claim_core_test.sv
// Self-checking testbench for the hash slot find-or-claim block.
// Depends on hsfc_pkg and hash_slot_find_or_claim_core; a scoreboard class
// predicts every lookup from its own copy of the table and the size register.
`timescale 1ns / 1ps

module hash_slot_find_or_claim_core_test;

   localparam int TABLE_SLOTS = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 85;
   localparam int MAX_GAP     = 17;
   localparam int LONG_HOLD   = 400;

   // One result item as the block presents it.
   typedef struct packed {
      logic                               status;
      logic [hsfc_pkg::SLOT_OUT_W-1:0]    slot;
      logic                               newly_claimed;
   } lookup_type;

   // A predicted result, kept with its key for messages.
   typedef struct {
      logic [hsfc_pkg::KEY_W-1:0] key;
      lookup_type                 res;
   } pending_lookup_type;

   // Scoreboard: mirrors the slot table and queues the predicted results.
   class slot_table_tracker;
      logic [hsfc_pkg::KEY_W-1:0]  stored_key [TABLE_SLOTS];
      bit                          slot_taken [TABLE_SLOTS];
      logic [hsfc_pkg::SIZE_W-1:0] size_reg;
      pending_lookup_type          expected_q [$];
      int unsigned                 failures;

      function new();
         size_reg = hsfc_pkg::SIZE_RESET;
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         failures = 0;
      endfunction

      function void set_size(input logic [hsfc_pkg::SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // 32-bit FNV-1a over the four key bytes, low byte first.
      function logic [31:0] fnv1a(input logic [31:0] key);
         logic [31:0] h;
         int          b;
         h = hsfc_pkg::FNV_BASIS;
         for (b = 0; b < 4; b++) begin
            h = h ^ {24'd0, key[8*b +: 8]};
            h = h * hsfc_pkg::FNV_PRIME;
         end
         return h;
      endfunction

      // Linear probe from hashed slot; finds key or claims first empty slot.
      function lookup_type find_or_claim(input logic [31:0] key);
         logic [31:0] n;
         int          idx;
         int          i;
         lookup_type  r;
         n = size_reg;
         if (n == 0) n = 1;
         if (n > TABLE_SLOTS) n = TABLE_SLOTS;
         idx = int'(fnv1a(key) % n);
         for (i = 0; i < n; i++) begin
            if (!slot_taken[idx]) begin
               slot_taken[idx] = 1'b1;
               stored_key[idx] = key;
               r = '{hsfc_pkg::STATUS_OK, 6'(idx), 1'b1};
               return r;
            end
            if (stored_key[idx] == key) begin
               r = '{hsfc_pkg::STATUS_OK, 6'(idx), 1'b0};
               return r;
            end
            idx = (idx + 1 == n) ? 0 : idx + 1;
         end
         r = '{hsfc_pkg::STATUS_FULL, 6'd0, 1'b0};
         return r;
      endfunction

      // Called for every accepted input item.
      function void note_key(input logic [31:0] key);
         pending_lookup_type p;
         p.key = key;
         p.res = find_or_claim(key);
         expected_q.push_back(p);
      endfunction

      function void compare_field(input string name, input logic [31:0] key,
                                  input int unsigned want, input int unsigned got);
         if (want != got) begin
            $display("%0t: key %h %s expected %0d, actual %0d",
                     $time, key, name, want, got);
            failures++;
         end
      endfunction

      // Called for every accepted result item.
      function void check_result(input lookup_type got);
         pending_lookup_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, %s %0d slot %0d claimed %0d",
                     $time, "actual status", got.status, got.slot, got.newly_claimed);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", want.key, want.res.status, got.status);
         compare_field("slot", want.key, want.res.slot, got.slot);
         compare_field("newly_claimed", want.key, want.res.newly_claimed,
                       got.newly_claimed);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [hsfc_pkg::KEY_W-1:0]      req_key;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_status;
   logic [hsfc_pkg::SLOT_OUT_W-1:0] rsp_slot;
   logic                            rsp_newly_claimed;
   logic                            csr_wr_en;
   logic [hsfc_pkg::SIZE_W-1:0]     csr_wr_data;

   slot_table_tracker          board = new();
   logic [hsfc_pkg::KEY_W-1:0] sent_keys [$];
   bit                         pace_idle = 1'b1;
   int                         hold_off_cycles = 0;
   int                         cycle_count = 0;

   hash_slot_find_or_claim_core #(
      .TABLE_DEPTH(TABLE_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot(rsp_slot),
      .rsp_newly_claimed(rsp_newly_claimed),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one key after a random gap and wait until it is accepted.
   // Valid stays high after acceptance so a zero gap keeps it high.
   task automatic send_key(input logic [31:0] key);
      int gap;
      gap = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_key(key);
      sent_keys.push_back(key);
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [hsfc_pkg::SIZE_W-1:0] value);
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_size(value);
   endtask

   // Mix of repeated keys, keys near both ends of the range and random keys.
   function automatic logic [31:0] pick_key();
      int choice;
      choice = $urandom_range(0, 9);
      if (choice < 4 && sent_keys.size() != 0)
         return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      if (choice == 4) return 32'($urandom_range(0, 255));
      if (choice == 5) return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      return $urandom;
   endfunction

   // Result side: random stall before each item, plus one long hold-off on request.
   initial begin : result_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result('{rsp_status, rsp_slot, rsp_newly_claimed});
         @(negedge clock);
      end
   end

   // Stimulus: directed keys and size corners, then random phases per size.
   initial begin : stimulus
      logic [31:0]                 directed_keys [14];
      logic [hsfc_pkg::SIZE_W-1:0] phase_sizes [12];
      logic [hsfc_pkg::SIZE_W-1:0] sz;
      int                          ph;

      directed_keys = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                        32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                        32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000,
                        32'hA5A5_A5A5, 32'h5A5A_5A5A};
      phase_sizes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd13, 7'd21,
                      7'd34, 7'd64, 7'd127, 7'd65};

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_key     = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset size: first claims, key zero, repeats that must be found.
      foreach (directed_keys[i]) send_key(directed_keys[i]);
      drain_results();

      // Size zero probes slot 0 only; an oversized value acts as the full depth.
      write_size(7'd0);
      send_key(32'h0000_0001);
      send_key(32'h1234_5678);
      drain_results();
      write_size(7'd127);
      send_key(32'h1234_5678);
      send_key(32'h0000_0001);
      drain_results();

      for (ph = 0; ph < 14; ph++) begin
         sz = (ph < 12) ? phase_sizes[ph] : 7'($urandom_range(0, 127));
         write_size(sz);
         pace_idle = (ph % 3 != 1);
         // Long result stall while keys keep coming, so the block backs up.
         if (ph == 4) hold_off_cycles = LONG_HOLD;
         repeat (PHASE_ITEMS) begin
            send_key(pick_key());
            if ($urandom_range(0, 49) == 0) drain_results();
         end
         drain_results();
      end

      repeat (40) @(negedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/hsfc_pkg.sv
rtl/hsfc_hash_unit.sv
rtl/hash_slot_find_or_claim_core.sv
tb/hash_slot_find_or_claim_core_test.sv
